>>> src/kph_pkg.sv
// Shared types and constants for the key press and hold table.
// No dependencies; imported by key_press_and_hold_table.
`default_nettype none

package kph_pkg;

   // Key code width of one event word
   localparam int CODE_W = 31;

   // Event mode codes
   typedef enum logic [1:0] {
      MODE_DOWN  = 2'd0,
      MODE_UP    = 2'd1,
      MODE_CLEAR = 2'd2,
      MODE_QUERY = 2'd3
   } mode_type;

   // Sequencer states, one-hot
   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_FINISH = 3'b100
   } state_type;

endpackage

`default_nettype wire

>>> src/key_press_and_hold_table.sv
// Key press and hold table: pressed list and held table with a serial scan.
// Depends on kph_pkg for mode codes, state codes and the key code width.
//
// Usage:
//   Drive req_mode and req_key_code and raise start while busy is low; the
//   word is taken at that clock edge and busy rises on the next cycle.
//   Key-down appends to the pressed list (until full) and places the key in
//   the held table once (if a slot is free); key-up frees every held slot
//   of that key; clear empties the pressed list; query changes nothing.
//   One result word follows each request: rsp_valid is high for exactly one
//   cycle with rsp_key_pressed, rsp_key_held, rsp_pressed_full and
//   rsp_held_full describing the state after the request.
//   A single shared compare stage walks both tables one slot a cycle over
//   N = max(pressed count, used held slots) slots.
//   busy stays high until the result is shown, so the next request is taken
//   in the cycle rsp_valid is high.
//   The receiver cannot stall: the result word is shown once and dropped.
//   Reset (synchronous, active high) empties both tables: counts and slot
//   valid bits go to zero; the code stores need no clearing.
`default_nettype none

module key_press_and_hold_table #(
   parameter int TABLE_DEPTH = 10
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire kph_pkg::mode_type         req_mode,
   input  wire logic [kph_pkg::CODE_W-1:0] req_key_code,
   output logic                           rsp_valid,
   output logic                           rsp_key_pressed,
   output logic                           rsp_key_held,
   output logic                           rsp_pressed_full,
   output logic                           rsp_held_full
);

   import kph_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(TABLE_DEPTH);

   // Code stores
   logic [CODE_W-1:0] pressed_mem [TABLE_DEPTH];
   logic [CODE_W-1:0] held_mem    [TABLE_DEPTH];

   // Sequencer and request word
   state_type         state_ff, state_in;
   mode_type          mode_ff;
   logic [CODE_W-1:0] code_ff;
   logic [CNT_W-1:0]  scan_len_ff, scan_len_in;
   logic [CNT_W-1:0]  rd_idx_ff, rd_idx_in;

   // Compare stage
   logic              cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]  cmp_idx_ff, cmp_idx_in;
   logic [CODE_W-1:0] p_rd_ff, h_rd_ff;

   // Scan accumulators
   logic              pm_ff, pm_in;
   logic              hm_ff, hm_in;
   logic [1:0]        fcnt_ff, fcnt_in;
   logic [IDX_W-1:0]  flast_ff, flast_in;

   // Table state
   logic [CNT_W-1:0]       pressed_count_ff, pressed_count_in;
   logic [CNT_W-1:0]       held_used_ff, held_used_in;
   logic [TABLE_DEPTH-1:0] held_valid_ff, held_valid_in;

   // Result word
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_pressed_ff, rsp_pressed_in;
   logic rsp_held_ff, rsp_held_in;
   logic rsp_pfull_ff, rsp_pfull_in;
   logic rsp_hfull_ff, rsp_hfull_in;

   // Combinational helpers
   logic             accept;
   logic             issue;
   logic             p_hit, h_valid, h_used, h_hit, h_freed;
   logic             p_app;
   logic             h_we;
   logic [IDX_W-1:0] h_slot;
   logic             freed_after;

   assign accept = start && (state_ff == ST_IDLE);
   assign busy   = (state_ff != ST_IDLE);
   assign issue  = (state_ff == ST_SCAN) && (rd_idx_ff < scan_len_ff);

   // Compare one slot of each table against the request key
   always_comb begin
      h_valid = held_valid_ff[cmp_idx_ff];
      h_used  = CNT_W'(cmp_idx_ff) < held_used_ff;
      p_hit   = (CNT_W'(cmp_idx_ff) < pressed_count_ff) && (p_rd_ff == code_ff);
      h_hit   = h_used && h_valid && (h_rd_ff == code_ff);
      h_freed = h_used && !h_valid;
   end

   // Sequence the scan and work out the table update
   always_comb begin
      state_in         = state_ff;
      scan_len_in      = scan_len_ff;
      rd_idx_in        = rd_idx_ff;
      cmp_vld_in       = 1'b0;
      cmp_idx_in       = cmp_idx_ff;
      pm_in            = pm_ff;
      hm_in            = hm_ff;
      fcnt_in          = fcnt_ff;
      flast_in         = flast_ff;
      pressed_count_in = pressed_count_ff;
      held_used_in     = held_used_ff;
      held_valid_in    = held_valid_ff;
      rsp_valid_in     = 1'b0;
      rsp_pressed_in   = rsp_pressed_ff;
      rsp_held_in      = rsp_held_ff;
      rsp_pfull_in     = rsp_pfull_ff;
      rsp_hfull_in     = rsp_hfull_ff;
      p_app            = 1'b0;
      h_we             = 1'b0;
      h_slot           = flast_ff;
      freed_after      = (fcnt_ff != 2'd0);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in    = ST_SCAN;
               rd_idx_in   = '0;
               scan_len_in = (pressed_count_ff > held_used_ff) ? pressed_count_ff
                                                               : held_used_ff;
               pm_in       = 1'b0;
               hm_in       = 1'b0;
               fcnt_in     = 2'd0;
               flast_in    = '0;
            end
         end

         ST_SCAN: begin
            // advance the read address
            if (issue) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = rd_idx_ff[IDX_W-1:0];
               rd_idx_in  = rd_idx_ff + 1'b1;
            end else if (!cmp_vld_ff) begin
               state_in = ST_FINISH;
            end
            // accumulate matches and freed slots; key-up frees on match
            if (cmp_vld_ff) begin
               if (p_hit) pm_in = 1'b1;
               if (h_hit) begin
                  hm_in = 1'b1;
                  if (mode_ff == MODE_UP) held_valid_in[cmp_idx_ff] = 1'b0;
               end
               if (h_freed) begin
                  flast_in = cmp_idx_ff;
                  if (fcnt_ff != 2'd2) fcnt_in = fcnt_ff + 1'b1;
               end
            end
         end

         ST_FINISH: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            rsp_pressed_in = pm_ff;
            rsp_held_in    = hm_ff;
            case (mode_ff)
               MODE_DOWN: begin
                  p_app = (pressed_count_ff < DEPTH_C);
                  if (p_app) pressed_count_in = pressed_count_ff + 1'b1;
                  rsp_pressed_in = pm_ff || p_app;
                  if (!hm_ff) begin
                     if (fcnt_ff != 2'd0) begin
                        // reuse the last freed slot
                        h_we        = 1'b1;
                        h_slot      = flast_ff;
                        freed_after = (fcnt_ff == 2'd2);
                        rsp_held_in = 1'b1;
                     end else if (held_used_ff < DEPTH_C) begin
                        // append a fresh slot
                        h_we         = 1'b1;
                        h_slot       = held_used_ff[IDX_W-1:0];
                        held_used_in = held_used_ff + 1'b1;
                        rsp_held_in  = 1'b1;
                     end
                  end
               end
               MODE_UP: begin
                  freed_after = (fcnt_ff != 2'd0) || hm_ff;
                  rsp_held_in = 1'b0;
               end
               MODE_CLEAR: begin
                  pressed_count_in = '0;
                  rsp_pressed_in   = 1'b0;
               end
               default: begin
               end
            endcase
            if (h_we) held_valid_in[h_slot] = 1'b1;
            rsp_pfull_in = (pressed_count_in == DEPTH_C);
            rsp_hfull_in = (held_used_in == DEPTH_C) && !freed_after;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Pressed list store: append on key-down, read one slot per scan cycle
   always_ff @(posedge clock) begin
      if (p_app) pressed_mem[pressed_count_ff[IDX_W-1:0]] <= code_ff;
      p_rd_ff <= pressed_mem[rd_idx_ff[IDX_W-1:0]];
   end

   // Held table store: fill a slot on key-down, read one slot per scan cycle
   always_ff @(posedge clock) begin
      if (h_we) held_mem[h_slot] <= code_ff;
      h_rd_ff <= held_mem[rd_idx_ff[IDX_W-1:0]];
   end

   // Hold the request word, compare index, scan accumulators and result word
   always_ff @(posedge clock) begin
      if (accept) begin
         mode_ff <= req_mode;
         code_ff <= req_key_code;
      end
      scan_len_ff    <= scan_len_in;
      rd_idx_ff      <= rd_idx_in;
      cmp_idx_ff     <= cmp_idx_in;
      pm_ff          <= pm_in;
      hm_ff          <= hm_in;
      fcnt_ff        <= fcnt_in;
      flast_ff       <= flast_in;
      rsp_pressed_ff <= rsp_pressed_in;
      rsp_held_ff    <= rsp_held_in;
      rsp_pfull_ff   <= rsp_pfull_in;
      rsp_hfull_ff   <= rsp_hfull_in;
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         cmp_vld_ff       <= 1'b0;
         pressed_count_ff <= '0;
         held_used_ff     <= '0;
         held_valid_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         cmp_vld_ff       <= cmp_vld_in;
         pressed_count_ff <= pressed_count_in;
         held_used_ff     <= held_used_in;
         held_valid_ff    <= held_valid_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_key_pressed  = rsp_pressed_ff;
   assign rsp_key_held     = rsp_held_ff;
   assign rsp_pressed_full = rsp_pfull_ff;
   assign rsp_held_full    = rsp_hfull_ff;

endmodule

`default_nettype wire
